@@ rtl/core/mic_pkg.sv @@
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the incremental conductance tracker: field
// widths, register indexes, sequencer states and calculation steps.
// ----------------------------------------------------------------------------
package mic_pkg;

   localparam int PanelMvWidth  = 15;
   localparam int PanelMaWidth  = 13;
   localparam int BattCodeWidth = 10;
   localparam int PowerWidth    = 28;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 13;

   // shared multiplier operand and kept product widths
   localparam int MulAWidth  = 30;
   localparam int MulBWidth  = 24;
   localparam int ProdWidth  = 46;
   localparam int NumWidth   = 30;
   localparam int VbWidth    = 23;

   localparam int VoltFloorMv   = 100;
   localparam int DutyResumeVal = 500;

   // battery mV = code * 5000 / 1023, compared by cross multiplication
   localparam int BattScaleMv    = 5000;
   localparam int AdcFullCode    = 1023;
   // estimate I*V*95/(300*Vb) < taper  <=>  I*V*95*1023 < taper*1500000*code
   localparam int EstNumerator   = 95 * 1023;
   localparam int EstDenominator = 300 * 5000;

   localparam int StepSizeReset   = 2;
   localparam int VoltDbReset     = 20;
   localparam int CurrDbReset     = 5;
   localparam int CondDbReset     = 10;
   localparam int FullLevelReset  = 4180;
   localparam int OverLevelReset  = 4230;
   localparam int ResumeLevelReset = 4140;
   localparam int TaperReset      = 220;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_STEP_SIZE,
      CSR_VOLT_DEADBAND,
      CSR_CURRENT_DEADBAND,
      CSR_COND_DEADBAND,
      CSR_FULL_LEVEL,
      CSR_OVERVOLT_LEVEL,
      CSR_RESUME_LEVEL,
      CSR_TAPER_CURRENT
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } state_type;

   // one multiplier product per step, consumed in the step after
   typedef enum logic [3:0] {
      STP_POWER,
      STP_DI_V,
      STP_DV_I,
      STP_SUM,
      STP_GCMP,
      STP_LHS,
      STP_TAPER,
      STP_RHS,
      STP_VB,
      STP_FULL,
      STP_OVER,
      STP_RESUME,
      STP_LAST
   } calc_step_type;

endpackage

@@ rtl/core/mic_ifs.sv @@
// ----------------------------------------------------------------------------
// mic channel interfaces
// Sample channel, result channel and register write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface mic_req_if;
   import mic_pkg::*;

   logic                            valid;
   logic                            ready;
   logic [PanelMvWidth-1:0]         panel_mv;
   logic signed [PanelMaWidth-1:0]  panel_ma;
   logic [BattCodeWidth-1:0]        battery_code;

   modport source (output valid, output panel_mv, output panel_ma,
                   output battery_code, input ready);
   modport sink   (input valid, input panel_mv, input panel_ma,
                   input battery_code, output ready);
endinterface

interface mic_rsp_if #(
   parameter int DUTY_WIDTH = 10
);
   import mic_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [DUTY_WIDTH-1:0]         duty;
   logic                          charge_stopped;
   logic signed [PowerWidth-1:0]  power_uw;

   modport source (output valid, output duty, output charge_stopped,
                   output power_uw, input ready);
   modport sink   (input valid, input duty, input charge_stopped,
                   input power_uw, output ready);
endinterface

interface mic_csr_if;
   import mic_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mppt_incremental_conductance_unit.sv @@
// ----------------------------------------------------------------------------
// mppt_incremental_conductance_unit
// Incremental conductance maximum power point tracker with battery charge
// cutoff. One shared signed multiplier, stepped by a small sequencer, forms
// the power, the conductance test and the battery cross products.
//
//   channel   dir   payload                                  handshake
//   req_chan  in    panel_mv, panel_ma, battery_code         valid/ready
//   rsp_chan  out   duty, charge_stopped, power_uw           valid/ready
//   csr_chan  in    index, data                              valid/ready
//
// An item passes through the idle state to take the sample, 13 steps of the shared
// multiplier (twelve products, one consumed per step) and the finish state to commit.
// req_chan.ready is high only while the sequencer is idle and reset is low.
// A result waits in the output register; the next sample is taken meanwhile,
// but its commit waits until the previous result has been transferred.
// Reset is synchronous and restores registers, duty 500 and no cutoff.
// csr_chan is ready whenever reset is low.
// ----------------------------------------------------------------------------
module mppt_incremental_conductance_unit #(
   parameter int DUTY_WIDTH = 10
) (
   input  logic      clock,
   input  logic      reset,
   mic_req_if.sink   req_chan,
   mic_rsp_if.source rsp_chan,
   mic_csr_if.sink   csr_chan
);
   import mic_pkg::*;

   localparam int DutyMaxInt = (1 << DUTY_WIDTH) - 1;
   localparam logic [DUTY_WIDTH-1:0] DutyResume =
      DUTY_WIDTH'((DutyResumeVal > DutyMaxInt) ? DutyMaxInt : DutyResumeVal);
   localparam logic [DUTY_WIDTH-1:0] DutyMax = '1;

   // configuration registers
   logic [5:0]  step_size_ff;
   logic [9:0]  volt_db_ff;
   logic [9:0]  curr_db_ff;
   logic [9:0]  cond_db_ff;
   logic [12:0] full_ff;
   logic [12:0] over_ff;
   logic [12:0] resume_ff;
   logic [11:0] taper_ff;

   // tracker state
   logic [PanelMvWidth-1:0]        prev_v_ff;
   logic signed [PanelMaWidth-1:0] prev_i_ff;
   logic [DUTY_WIDTH-1:0]          duty_ff;
   logic [DUTY_WIDTH-1:0]          duty_in;
   logic                           cut_ff;
   logic                           cut_in;

   // sequencer
   state_type     state_ff;
   state_type     state_in;
   calc_step_type step_ff;
   logic          req_fire;
   logic          finish_go;

   // sample registers
   logic [PanelMvWidth-1:0]         raw_v_ff;
   logic [PanelMvWidth-1:0]         v_ff;
   logic [PanelMvWidth-1:0]         v_in;
   logic signed [PanelMaWidth-1:0]  cur_ff;
   logic [BattCodeWidth-1:0]        code_ff;
   logic signed [PanelMvWidth:0]    dv_ff;
   logic signed [PanelMvWidth:0]    dv_in;
   logic signed [PanelMaWidth:0]    di_ff;
   logic signed [PanelMaWidth:0]    di_in;

   // shared multiplier
   logic signed [MulAWidth-1:0]           mul_a;
   logic signed [MulBWidth-1:0]           mul_b;
   logic signed [MulAWidth+MulBWidth-1:0] mul_full;
   logic signed [ProdWidth-1:0]           prod_ff;

   // intermediate results
   logic signed [PowerWidth-1:0] power_ff;
   logic signed [PowerWidth-1:0] rsp_power_ff;
   logic                         rsp_valid_ff;
   logic signed [NumWidth-1:0]   num_ff;
   logic signed [ProdWidth-1:0]  lhs_ff;
   logic [VbWidth-1:0]           vb_ff;
   logic                         trk_up_ff;
   logic                         trk_dn_ff;
   logic                         lt_taper_ff;
   logic                         gt_full_ff;
   logic                         gt_over_ff;
   logic                         lt_resume_ff;

   logic [PanelMvWidth-1:0] abs_dv;
   logic [10:0]             cond_k;

   // tracking decision
   logic signed [PanelMvWidth+1:0] dv_wide;
   logic signed [PanelMvWidth+1:0] vdb_wide;
   logic signed [PanelMaWidth+1:0] di_wide;
   logic signed [PanelMaWidth+1:0] idb_wide;
   logic signed [ProdWidth-1:0]    num_ext;
   logic                           in_band;
   logic                           g_ge;
   logic                           g_le;
   logic                           trk_up;
   logic                           trk_dn;

   logic [DUTY_WIDTH-1:0] duty_step;
   logic [DUTY_WIDTH:0]   duty_sum;
   logic [DUTY_WIDTH-1:0] trk_duty;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= 6'(StepSizeReset);
         volt_db_ff   <= 10'(VoltDbReset);
         curr_db_ff   <= 10'(CurrDbReset);
         cond_db_ff   <= 10'(CondDbReset);
         full_ff      <= 13'(FullLevelReset);
         over_ff      <= 13'(OverLevelReset);
         resume_ff    <= 13'(ResumeLevelReset);
         taper_ff     <= 12'(TaperReset);
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_STEP_SIZE:        step_size_ff <= csr_chan.data[5:0];
            CSR_VOLT_DEADBAND:    volt_db_ff   <= csr_chan.data[9:0];
            CSR_CURRENT_DEADBAND: curr_db_ff   <= csr_chan.data[9:0];
            CSR_COND_DEADBAND:    cond_db_ff   <= csr_chan.data[9:0];
            CSR_FULL_LEVEL:       full_ff      <= csr_chan.data[12:0];
            CSR_OVERVOLT_LEVEL:   over_ff      <= csr_chan.data[12:0];
            CSR_RESUME_LEVEL:     resume_ff    <= csr_chan.data[12:0];
            CSR_TAPER_CURRENT:    taper_ff     <= csr_chan.data[11:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            if (step_ff == STP_LAST) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE) && !reset;
      finish_go      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STP_POWER;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            step_ff <= STP_POWER;
         end else if (state_ff == ST_CALC && step_ff != STP_LAST) begin
            step_ff <= calc_step_type'(step_ff + 4'd1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // sample capture
   // ---------------------------------------------------------------------
   always_comb begin
      v_in  = (req_chan.panel_mv < PanelMvWidth'(VoltFloorMv)) ?
              PanelMvWidth'(VoltFloorMv) : req_chan.panel_mv;
      dv_in = $signed({1'b0, v_in}) - $signed({1'b0, prev_v_ff});
      di_in = (PanelMaWidth+1)'(req_chan.panel_ma) - (PanelMaWidth+1)'(prev_i_ff);
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         raw_v_ff <= req_chan.panel_mv;
         v_ff     <= v_in;
         cur_ff   <= req_chan.panel_ma;
         code_ff  <= req_chan.battery_code;
         dv_ff    <= dv_in;
         di_ff    <= di_in;
      end
   end

   // ---------------------------------------------------------------------
   // shared multiplier, operands picked by step
   // ---------------------------------------------------------------------
   assign abs_dv = dv_ff[PanelMvWidth] ? PanelMvWidth'(-dv_ff) : PanelMvWidth'(dv_ff);
   assign cond_k = 11'(cond_db_ff) + 11'd1;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         STP_POWER: begin
            mul_a = MulAWidth'(raw_v_ff);
            mul_b = MulBWidth'(cur_ff);
         end
         STP_DI_V: begin
            mul_a = MulAWidth'(di_ff);
            mul_b = MulBWidth'(v_ff);
         end
         STP_DV_I: begin
            mul_a = MulAWidth'(dv_ff);
            mul_b = MulBWidth'(cur_ff);
         end
         STP_SUM: begin
            mul_a = MulAWidth'(cond_k);
            mul_b = MulBWidth'(abs_dv);
         end
         STP_GCMP: begin
            mul_a = MulAWidth'(cur_ff);
            mul_b = MulBWidth'(v_ff);
         end
         STP_LHS: begin
            mul_a = MulAWidth'(prod_ff);
            mul_b = MulBWidth'(EstNumerator);
         end
         STP_TAPER: begin
            mul_a = MulAWidth'(taper_ff);
            mul_b = MulBWidth'(code_ff);
         end
         STP_RHS: begin
            mul_a = MulAWidth'(prod_ff);
            mul_b = MulBWidth'(EstDenominator);
         end
         STP_VB: begin
            mul_a = MulAWidth'(code_ff);
            mul_b = MulBWidth'(BattScaleMv);
         end
         STP_FULL: begin
            mul_a = MulAWidth'(full_ff);
            mul_b = MulBWidth'(AdcFullCode);
         end
         STP_OVER: begin
            mul_a = MulAWidth'(over_ff);
            mul_b = MulBWidth'(AdcFullCode);
         end
         STP_RESUME: begin
            mul_a = MulAWidth'(resume_ff);
            mul_b = MulBWidth'(AdcFullCode);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // ---------------------------------------------------------------------
   // tracking decision, taken while prod_ff holds (cond_db+1)*|dV|
   // g > db  <=>  N/dV >= db+1, g < -db  <=>  N/dV <= -(db+1)
   // ---------------------------------------------------------------------
   always_comb begin
      dv_wide  = (PanelMvWidth+2)'(dv_ff);
      vdb_wide = $signed((PanelMvWidth+2)'(volt_db_ff));
      di_wide  = (PanelMaWidth+2)'(di_ff);
      idb_wide = $signed((PanelMaWidth+2)'(curr_db_ff));
      num_ext  = ProdWidth'(num_ff);
      in_band  = (dv_wide > -vdb_wide) && (dv_wide < vdb_wide);
      g_ge     = (num_ext >= prod_ff);
      g_le     = (num_ext <= -prod_ff);
      if (in_band) begin
         trk_up = (di_wide > idb_wide);
         trk_dn = (di_wide < -idb_wide);
      end else if (dv_ff == '0) begin
         // zero deadband: infinite conductance with the sign of dI
         trk_up = !di_ff[PanelMaWidth] && (di_ff != '0);
         trk_dn = di_ff[PanelMaWidth];
      end else if (!dv_ff[PanelMvWidth]) begin
         trk_up = g_ge;
         trk_dn = g_le;
      end else begin
         trk_up = g_le;
         trk_dn = g_ge;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         prod_ff <= mul_full[ProdWidth-1:0];
         case (step_ff)
            STP_DI_V:   power_ff     <= prod_ff[PowerWidth-1:0];
            STP_DV_I:   num_ff       <= prod_ff[NumWidth-1:0];
            STP_SUM:    num_ff       <= num_ff + $signed(prod_ff[NumWidth-1:0]);
            STP_GCMP: begin
               trk_up_ff <= trk_up;
               trk_dn_ff <= trk_dn;
            end
            STP_TAPER:  lhs_ff       <= prod_ff;
            STP_VB:     lt_taper_ff  <= (lhs_ff < prod_ff);
            STP_FULL:   vb_ff        <= prod_ff[VbWidth-1:0];
            STP_OVER:   gt_full_ff   <= (vb_ff > prod_ff[VbWidth-1:0]);
            STP_RESUME: gt_over_ff   <= (vb_ff > prod_ff[VbWidth-1:0]);
            STP_LAST:   lt_resume_ff <= (vb_ff < prod_ff[VbWidth-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // duty step, clamp and cutoff hysteresis
   // ---------------------------------------------------------------------
   always_comb begin
      duty_step = DUTY_WIDTH'(step_size_ff);
      duty_sum  = {1'b0, duty_ff} + {1'b0, duty_step};
      if (trk_up_ff) begin
         trk_duty = duty_sum[DUTY_WIDTH] ? DutyMax : duty_sum[DUTY_WIDTH-1:0];
      end else if (trk_dn_ff) begin
         trk_duty = (duty_ff < duty_step) ? '0 : duty_ff - duty_step;
      end else begin
         trk_duty = duty_ff;
      end

      if (gt_full_ff) begin
         cut_in = (lt_taper_ff || gt_over_ff) ? 1'b1 : cut_ff;
      end else if (lt_resume_ff) begin
         cut_in = 1'b0;
      end else begin
         cut_in = cut_ff;
      end

      if (cut_in) begin
         duty_in = DutyMax;
      end else if (cut_ff) begin
         duty_in = DutyResume;
      end else begin
         duty_in = trk_duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_v_ff    <= '0;
         prev_i_ff    <= '0;
         duty_ff      <= DutyResume;
         cut_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            prev_v_ff    <= v_ff;
            prev_i_ff    <= cur_ff;
            duty_ff      <= duty_in;
            cut_ff       <= cut_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) rsp_power_ff <= power_ff;
   end

   // duty and cutoff state only change on a commit, after the slot is free
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.duty           = duty_ff;
   assign rsp_chan.charge_stopped = cut_ff;
   assign rsp_chan.power_uw       = rsp_power_ff;

endmodule
